/* hw/rtl/prk_pkg.sv */
// ----------------------------------------------------------------------------
// prk_pkg: shared types and constants of the pendulum RK step block
// Channel payloads, register indexes, method and sequencer codes, and the
// saturation and stage-plan helpers used by the datapath.
// ----------------------------------------------------------------------------
package prk_pkg;

  // Field widths
  localparam int unsigned STATE_W = 32;
  localparam int unsigned TIME_W  = 48;
  localparam int unsigned DT_W    = 25;
  localparam int unsigned STIFF_W = 31;
  localparam int unsigned WIDE_W  = 41;   // headroom for sums before saturation
  localparam int unsigned PROD_W  = 64;
  localparam int unsigned ACC_W   = 62;

  // Channel payloads
  typedef struct packed {
    logic                      operation;
    logic signed [STATE_W-1:0] init_angle;
    logic signed [STATE_W-1:0] init_rate;
  } prk_in_t;

  typedef struct packed {
    logic signed [STATE_W-1:0] angle;
    logic signed [STATE_W-1:0] rate;
    logic [TIME_W-1:0]         elapsed_time;
  } prk_out_t;

  typedef struct packed {
    logic [1:0]         reg_idx;
    logic [STIFF_W-1:0] wr_data;
  } prk_cfg_t;

  // Register indexes
  localparam logic [1:0] CFG_STEP_SIZE = 2'd0;
  localparam logic [1:0] CFG_STIFFNESS = 2'd1;
  localparam logic [1:0] CFG_METHOD    = 2'd2;

  // Register reset values
  localparam logic [DT_W-1:0]    STEP_SIZE_RST = 25'd1677722;
  localparam logic [STIFF_W-1:0] STIFFNESS_RST = 31'd164584489;
  localparam logic [1:0]         METHOD_RST    = 2'd2;

  // Method codes; any other code runs classic RK4
  localparam logic [1:0] METHOD_EULER = 2'd0;
  localparam logic [1:0] METHOD_MID   = 2'd1;

  // Operations
  localparam logic OP_LOAD    = 1'b0;
  localparam logic OP_ADVANCE = 1'b1;

  // Sequencer phase within one stage: derivative, angle product, rate product
  localparam logic [1:0] PH_DERIV = 2'd0;
  localparam logic [1:0] PH_ANGLE = 2'd1;
  localparam logic [1:0] PH_RATE  = 2'd2;

  // How a stage product updates the state
  localparam logic [1:0] UPD_NONE  = 2'd0;
  localparam logic [1:0] UPD_HALF  = 2'd1;
  localparam logic [1:0] UPD_FULL  = 2'd2;
  localparam logic [1:0] UPD_FINAL = 2'd3;

  // Weight of a stage product in the RK4 sum
  localparam logic [1:0] W_NONE = 2'd0;
  localparam logic [1:0] W_ONE  = 2'd1;
  localparam logic [1:0] W_TWO  = 2'd2;

  typedef struct packed {
    logic [1:0] upd;
    logic [1:0] weight;
    logic       last;
  } plan_t;

  // Writeback tag that travels with the product register
  typedef struct packed {
    logic       valid;
    logic [1:0] phase;
    logic [1:0] upd;
    logic [1:0] weight;
  } wb_t;

  // Rounding constants (half of 2^24, half of 2^25, half of 6 * 2^24)
  localparam logic signed [PROD_W-1:0] RND24   = 64'sd8388608;
  localparam logic signed [PROD_W-1:0] RND25   = 64'sd16777216;
  localparam logic signed [ACC_W-1:0]  RND_SIX = 62'sd50331648;

  // Divide-by-three unit: one byte digit per cycle
  localparam int unsigned DIV_W       = 40;
  localparam int unsigned DIV_DIGIT_W = 8;
  localparam int unsigned DIV_DIGITS  = DIV_W / DIV_DIGIT_W;
  localparam int unsigned DIV_CNT_W   = 3;
  localparam logic [9:0]  DIV3_RECIP  = 10'd683;   // ceil(2^11 / 3)
  localparam int unsigned DIV3_SHIFT  = 11;
  // Bias that keeps the dividend positive, and its quotient
  localparam logic [DIV_W-1:0] DIV_OFFSET  = 40'h30_0000_0000;
  localparam logic [DIV_W-1:0] QUOT_OFFSET = 40'h10_0000_0000;

  localparam logic [TIME_W-1:0] TIME_MAX = '1;

  // Clamp a wide signed value to the 32-bit signed range
  function automatic logic signed [STATE_W-1:0] sat32(input logic signed [WIDE_W-1:0] v);
    logic signed [STATE_W-1:0] res;
    if (v > 41'sd2147483647) begin
      res = 32'sh7fff_ffff;
    end else if (v < -41'sd2147483648) begin
      res = 32'sh8000_0000;
    end else begin
      res = v[STATE_W-1:0];
    end
    return res;
  endfunction

  // Per-stage update plan of each method
  function automatic plan_t stage_plan(input logic [1:0] method, input logic [1:0] stage);
    plan_t p;
    p.upd    = UPD_NONE;
    p.weight = W_NONE;
    p.last   = 1'b0;
    case (method)
      METHOD_EULER: begin
        p.upd  = UPD_FINAL;
        p.last = 1'b1;
      end
      METHOD_MID: begin
        if (stage == 2'd0) begin
          p.upd = UPD_HALF;
        end else begin
          p.upd  = UPD_FINAL;
          p.last = 1'b1;
        end
      end
      default: begin
        case (stage)
          2'd0: begin
            p.upd    = UPD_HALF;
            p.weight = W_ONE;
          end
          2'd1: begin
            p.upd    = UPD_HALF;
            p.weight = W_TWO;
          end
          2'd2: begin
            p.upd    = UPD_FULL;
            p.weight = W_TWO;
          end
          default: begin
            p.upd    = UPD_NONE;
            p.weight = W_ONE;
            p.last   = 1'b1;
          end
        endcase
      end
    endcase
    return p;
  endfunction

endpackage

/* hw/rtl/prk_chan_if.sv */
// ----------------------------------------------------------------------------
// prk_chan_if: valid/ready channel
// One transfer happens at a rising edge with valid and ready both high.
// ----------------------------------------------------------------------------
interface prk_chan_if #(
  parameter type payload_t = logic
) ();

  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);

endinterface

/* hw/rtl/prk_mul.sv */
// ----------------------------------------------------------------------------
// prk_mul: shared signed multiplier
// 32 x 32 signed product, registered; one product per cycle when enabled.
// ----------------------------------------------------------------------------
module prk_mul (
  input  logic                                  clk,
  input  logic                                  en,
  input  logic signed [prk_pkg::STATE_W-1:0]    op_a,
  input  logic signed [prk_pkg::STATE_W-1:0]    op_b,
  output logic signed [prk_pkg::PROD_W-1:0]     prod
);

  logic signed [prk_pkg::PROD_W-1:0] prod_r;
  logic signed [prk_pkg::PROD_W-1:0] prod_nxt;

  // Form the full-width product
  assign prod_nxt = 64'(op_a) * 64'(op_b);

  // Hold the product for the writeback cycle
  always_ff @(posedge clk) begin
    if (en) begin
      prod_r <= prod_nxt;
    end
  end

  assign prod = prod_r;

endmodule

/* hw/rtl/prk_div3.sv */
// ----------------------------------------------------------------------------
// prk_div3: digit-serial divide by three
// Divides an unsigned 40-bit value by 3, one byte digit per cycle, MSB first.
// ----------------------------------------------------------------------------
module prk_div3 (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  input  logic [prk_pkg::DIV_W-1:0]     dividend,
  output logic                          done,
  output logic [prk_pkg::DIV_W-1:0]     quot
);

  localparam int unsigned DW = prk_pkg::DIV_DIGIT_W;

  logic                         run_r,  run_nxt;
  logic                         done_r, done_nxt;
  logic [prk_pkg::DIV_CNT_W-1:0] cnt_r, cnt_nxt;
  logic [prk_pkg::DIV_W-1:0]    dvd_r,  dvd_nxt;
  logic [prk_pkg::DIV_W-1:0]    quot_r, quot_nxt;
  logic [1:0]                   rem_r,  rem_nxt;

  logic [DW+1:0]  part;
  logic [19:0]    scaled;
  logic [DW-1:0]  qd;
  logic [DW+1:0]  rem_full;
  logic           last_digit;

  // Divide one partial remainder by 3 through a reciprocal multiply
  assign part     = {rem_r, dvd_r[prk_pkg::DIV_W-1 -: DW]};
  assign scaled   = 20'(part) * 20'(prk_pkg::DIV3_RECIP);
  assign qd       = scaled[prk_pkg::DIV3_SHIFT +: DW];
  assign rem_full = part - 10'(10'(qd) * 10'd3);
  assign last_digit = (cnt_r == prk_pkg::DIV_CNT_W'(prk_pkg::DIV_DIGITS - 1));

  // Advance one digit per cycle
  always_comb begin
    run_nxt  = run_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    dvd_nxt  = dvd_r;
    quot_nxt = quot_r;
    rem_nxt  = rem_r;
    if (start) begin
      run_nxt = 1'b1;
      cnt_nxt = '0;
      dvd_nxt = dividend;
      rem_nxt = '0;
    end else if (run_r) begin
      quot_nxt = {quot_r[prk_pkg::DIV_W-DW-1:0], qd};
      dvd_nxt  = {dvd_r[prk_pkg::DIV_W-DW-1:0], DW'(0)};
      rem_nxt  = rem_full[1:0];
      cnt_nxt  = cnt_r + 1'b1;
      if (last_digit) begin
        run_nxt  = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
    end else begin
      run_r  <= run_nxt;
      done_r <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cnt_r  <= cnt_nxt;
    dvd_r  <= dvd_nxt;
    quot_r <= quot_nxt;
    rem_r  <= rem_nxt;
  end

  assign done = done_r;
  assign quot = quot_r;

endmodule

/* hw/rtl/pendulum_runge_kutta_step.sv */
// ----------------------------------------------------------------------------
// pendulum_runge_kutta_step: one explicit RK step of a linearised pendulum
//
// Channels: in_ch takes items {operation, init_angle, init_rate}; a load
// (operation 0) sets angle and rate and clears time, an advance (operation 1)
// takes one Euler, midpoint or classic RK4 step of size step_size. out_ch
// gives {angle, rate, elapsed_time} once per item, in order. cfg_ch writes
// step_size (0), stiffness (1) and method_select (2); it is always ready.
// The user must write it only while the block is idle, which is not enforced.
//
// One item is in work at a time, and the next one can be taken in the cycle
// the result shows. The time an item takes is set by the single shared 32x32
// multiplier, used three times per stage, and for RK4 by the byte-serial
// divide by three run once for angle and once for rate.
//
// Reset: registers take their reset values, angle, rate and time clear,
// in_ch is ready after reset. A finished result sits in the output register;
// while the receiver stalls, the block may take one more item, works it and
// holds it until the output register is free.
// ----------------------------------------------------------------------------
module pendulum_runge_kutta_step (
  input  logic       clk,
  input  logic       rst_n,
  prk_chan_if.sink   in_ch,
  prk_chan_if.source out_ch,
  prk_chan_if.sink   cfg_ch
);

  localparam logic [2:0] S_IDLE    = 3'd0;
  localparam logic [2:0] S_RUN     = 3'd1;
  localparam logic [2:0] S_DRAIN   = 3'd2;
  localparam logic [2:0] S_DIVGO   = 3'd3;
  localparam logic [2:0] S_DIVWAIT = 3'd4;
  localparam logic [2:0] S_DONE    = 3'd5;

  localparam int unsigned SW = prk_pkg::STATE_W;
  localparam int unsigned WW = prk_pkg::WIDE_W;

  // Configuration registers
  logic [prk_pkg::DT_W-1:0]    step_size_r, step_size_nxt;
  logic [prk_pkg::STIFF_W-1:0] stiffness_r, stiffness_nxt;
  logic [1:0]                  method_r,    method_nxt;

  // Sequencer
  logic [2:0]   state_r, state_nxt;
  logic [1:0]   stage_r, stage_nxt;
  logic [1:0]   phase_r, phase_nxt;
  prk_pkg::wb_t wb_r,    wb_nxt;
  logic         div_var_r, div_var_nxt;

  // Datapath state
  logic signed [SW-1:0]              x0_r, x0_nxt;
  logic signed [SW-1:0]              x1_r, x1_nxt;
  logic signed [SW-1:0]              y0_r, y0_nxt;
  logic signed [SW-1:0]              y1_r, y1_nxt;
  logic signed [SW-1:0]              kr_r, kr_nxt;
  logic signed [prk_pkg::ACC_W-1:0]  acc0_r, acc0_nxt;
  logic signed [prk_pkg::ACC_W-1:0]  acc1_r, acc1_nxt;
  logic [prk_pkg::TIME_W-1:0]        time_r, time_nxt;

  // Output register
  logic              out_valid_r, out_valid_nxt;
  prk_pkg::prk_out_t out_r,       out_nxt;

  // Shared units
  logic                              mul_en;
  logic signed [SW-1:0]              mul_a, mul_b;
  logic signed [prk_pkg::PROD_W-1:0] prod;
  logic                              div_start;
  logic [prk_pkg::DIV_W-1:0]         div_dividend;
  logic                              div_done;
  logic [prk_pkg::DIV_W-1:0]         div_quot;

  // Datapath intermediates
  prk_pkg::plan_t                    plan;
  logic                              in_xfer;
  logic                              is_rk4;
  logic signed [SW-1:0]              dt_s;
  logic signed [prk_pkg::PROD_W-1:0] prod_rnd24, prod_rnd25;
  logic signed [39:0]                r24;
  logic signed [38:0]                r25;
  logic signed [SW-1:0]              wb_x;
  logic signed [SW-1:0]              new_half, new_full, kr_new;
  logic signed [prk_pkg::ACC_W-1:0]  prod_acc, addend;
  logic signed [prk_pkg::ACC_W-1:0]  acc_sel, acc_rnd;
  logic signed [36:0]                acc_div;
  logic signed [prk_pkg::DIV_W-1:0]  quot_s;
  logic signed [SW-1:0]              div_x, div_new;
  logic [prk_pkg::TIME_W:0]          time_sum;

  assign in_xfer = in_ch.valid && in_ch.ready;
  assign is_rk4  = (method_r != prk_pkg::METHOD_EULER) && (method_r != prk_pkg::METHOD_MID);
  assign plan    = prk_pkg::stage_plan(method_r, stage_r);
  assign dt_s    = signed'(SW'(step_size_r));

  // Select multiplier operands by phase
  always_comb begin
    mul_en = (state_r == S_RUN);
    case (phase_r)
      prk_pkg::PH_DERIV: begin
        mul_a = signed'({1'b0, stiffness_r});
        mul_b = y0_r;
      end
      prk_pkg::PH_ANGLE: begin
        mul_a = dt_s;
        mul_b = y1_r;
      end
      default: begin
        mul_a = dt_s;
        mul_b = kr_r;
      end
    endcase
  end

  prk_mul u_mul (
    .clk  (clk),
    .en   (mul_en),
    .op_a (mul_a),
    .op_b (mul_b),
    .prod (prod)
  );

  // Round the product at 2^24 and 2^25, halves upward
  assign prod_rnd24 = prod + prk_pkg::RND24;
  assign prod_rnd25 = prod + prk_pkg::RND25;
  assign r24        = prod_rnd24[63:24];
  assign r25        = prod_rnd25[63:25];
  assign wb_x       = (wb_r.phase == prk_pkg::PH_RATE) ? x1_r : x0_r;
  assign new_half   = prk_pkg::sat32(WW'(wb_x) + WW'(r25));
  assign new_full   = prk_pkg::sat32(WW'(wb_x) + WW'(r24));
  assign kr_new     = prk_pkg::sat32(-WW'(r24));

  // Weight the product for the RK4 sum
  assign prod_acc = prod[prk_pkg::ACC_W-1:0];
  always_comb begin
    case (wb_r.weight)
      prk_pkg::W_TWO: addend = {prod_acc[prk_pkg::ACC_W-2:0], 1'b0};
      prk_pkg::W_ONE: addend = prod_acc;
      default:        addend = '0;
    endcase
  end

  // Bias the RK4 sum for the divide by three: floor(floor((n + 3 * 2^24) / 2^25) / 3)
  assign acc_sel      = div_var_r ? acc1_r : acc0_r;
  assign acc_rnd      = acc_sel + prk_pkg::RND_SIX;
  assign acc_div      = acc_rnd[prk_pkg::ACC_W-1:25];
  assign div_dividend = prk_pkg::DIV_W'(acc_div) + prk_pkg::DIV_OFFSET;
  assign quot_s       = signed'(div_quot - prk_pkg::QUOT_OFFSET);
  assign div_x        = div_var_r ? x1_r : x0_r;
  assign div_new      = prk_pkg::sat32(WW'(div_x) + WW'(quot_s));

  prk_div3 u_div3 (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dividend),
    .done     (div_done),
    .quot     (div_quot)
  );

  // Saturating time update
  assign time_sum = {1'b0, time_r} + (prk_pkg::TIME_W + 1)'(step_size_r);

  // Decode configuration writes
  always_comb begin
    step_size_nxt = step_size_r;
    stiffness_nxt = stiffness_r;
    method_nxt    = method_r;
    if (cfg_ch.valid) begin
      unique case (cfg_ch.payload.reg_idx)
        prk_pkg::CFG_STEP_SIZE: step_size_nxt = cfg_ch.payload.wr_data[prk_pkg::DT_W-1:0];
        prk_pkg::CFG_STIFFNESS: stiffness_nxt = cfg_ch.payload.wr_data;
        prk_pkg::CFG_METHOD:    method_nxt    = cfg_ch.payload.wr_data[1:0];
        default: ;
      endcase
    end
  end

  // Sequencer and writeback
  always_comb begin
    state_nxt     = state_r;
    stage_nxt     = stage_r;
    phase_nxt     = phase_r;
    div_var_nxt   = div_var_r;
    x0_nxt        = x0_r;
    x1_nxt        = x1_r;
    y0_nxt        = y0_r;
    y1_nxt        = y1_r;
    kr_nxt        = kr_r;
    acc0_nxt      = acc0_r;
    acc1_nxt      = acc1_r;
    time_nxt      = time_r;
    out_nxt       = out_r;
    out_valid_nxt = out_valid_r && !out_ch.ready;
    div_start     = 1'b0;

    wb_nxt        = '0;
    wb_nxt.valid  = (state_r == S_RUN);
    wb_nxt.phase  = phase_r;
    wb_nxt.upd    = plan.upd;
    wb_nxt.weight = plan.weight;

    // Apply the product issued last cycle
    if (wb_r.valid) begin
      case (wb_r.phase)
        prk_pkg::PH_DERIV: kr_nxt = kr_new;
        prk_pkg::PH_ANGLE: begin
          acc0_nxt = acc0_r + addend;
          case (wb_r.upd)
            prk_pkg::UPD_HALF:  y0_nxt = new_half;
            prk_pkg::UPD_FULL:  y0_nxt = new_full;
            prk_pkg::UPD_FINAL: x0_nxt = new_full;
            default: ;
          endcase
        end
        default: begin
          acc1_nxt = acc1_r + addend;
          case (wb_r.upd)
            prk_pkg::UPD_HALF:  y1_nxt = new_half;
            prk_pkg::UPD_FULL:  y1_nxt = new_full;
            prk_pkg::UPD_FINAL: x1_nxt = new_full;
            default: ;
          endcase
        end
      endcase
    end

    unique case (state_r)
      S_IDLE: begin
        if (in_xfer) begin
          if (in_ch.payload.operation == prk_pkg::OP_LOAD) begin
            x0_nxt    = in_ch.payload.init_angle;
            x1_nxt    = in_ch.payload.init_rate;
            time_nxt  = '0;
            state_nxt = S_DONE;
          end else begin
            y0_nxt    = x0_r;
            y1_nxt    = x1_r;
            acc0_nxt  = '0;
            acc1_nxt  = '0;
            stage_nxt = '0;
            phase_nxt = prk_pkg::PH_DERIV;
            time_nxt  = time_sum[prk_pkg::TIME_W] ? prk_pkg::TIME_MAX
                                                  : time_sum[prk_pkg::TIME_W-1:0];
            state_nxt = S_RUN;
          end
        end
      end
      S_RUN: begin
        if (phase_r == prk_pkg::PH_RATE) begin
          phase_nxt = prk_pkg::PH_DERIV;
          stage_nxt = stage_r + 1'b1;
          if (plan.last) begin
            state_nxt = S_DRAIN;
          end
        end else begin
          phase_nxt = phase_r + 1'b1;
        end
      end
      S_DRAIN: begin
        div_var_nxt = 1'b0;
        state_nxt   = is_rk4 ? S_DIVGO : S_DONE;
      end
      S_DIVGO: begin
        div_start = 1'b1;
        state_nxt = S_DIVWAIT;
      end
      S_DIVWAIT: begin
        if (div_done) begin
          if (div_var_r) begin
            x1_nxt    = div_new;
            state_nxt = S_DONE;
          end else begin
            x0_nxt      = div_new;
            div_var_nxt = 1'b1;
            state_nxt   = S_DIVGO;
          end
        end
      end
      S_DONE: begin
        if (!out_valid_r || out_ch.ready) begin
          out_nxt.angle        = x0_r;
          out_nxt.rate         = x1_r;
          out_nxt.elapsed_time = time_r;
          out_valid_nxt        = 1'b1;
          state_nxt            = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // Control and architectural state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      wb_r        <= '0;
      out_valid_r <= 1'b0;
      step_size_r <= prk_pkg::STEP_SIZE_RST;
      stiffness_r <= prk_pkg::STIFFNESS_RST;
      method_r    <= prk_pkg::METHOD_RST;
      x0_r        <= '0;
      x1_r        <= '0;
      time_r      <= '0;
    end else begin
      state_r     <= state_nxt;
      wb_r        <= wb_nxt;
      out_valid_r <= out_valid_nxt;
      step_size_r <= step_size_nxt;
      stiffness_r <= stiffness_nxt;
      method_r    <= method_nxt;
      x0_r        <= x0_nxt;
      x1_r        <= x1_nxt;
      time_r      <= time_nxt;
    end
  end

  // Working registers and output payload
  always_ff @(posedge clk) begin
    stage_r   <= stage_nxt;
    phase_r   <= phase_nxt;
    div_var_r <= div_var_nxt;
    y0_r      <= y0_nxt;
    y1_r      <= y1_nxt;
    kr_r      <= kr_nxt;
    acc0_r    <= acc0_nxt;
    acc1_r    <= acc1_nxt;
    out_r     <= out_nxt;
  end

  assign in_ch.ready    = (state_r == S_IDLE);
  assign cfg_ch.ready   = 1'b1;
  assign out_ch.valid   = out_valid_r;
  assign out_ch.payload = out_r;

endmodule

/* hw/rtl/prk_checker.sv */
// ----------------------------------------------------------------------------
// prk_checker: port-level checks of the pendulum RK step block
// Tracks items accepted but not yet delivered and checks ordering of
// transfers against it.
// ----------------------------------------------------------------------------
module prk_checker (
  input logic              clk,
  input logic              rst_n,
  input logic              in_valid,
  input logic              in_ready,
  input logic              out_valid,
  input logic              out_ready,
  input prk_pkg::prk_out_t out_data
);

  logic [1:0] cnt_r, cnt_nxt;
  logic       in_xfer, out_xfer;

  assign in_xfer  = in_valid && in_ready;
  assign out_xfer = out_valid && out_ready;

  // Count items in flight
  always_comb begin
    cnt_nxt = cnt_r;
    if (in_xfer && !out_xfer) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (out_xfer && !in_xfer) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  // One item at a time: input closes right after a transfer
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_xfer |=> !in_ready)
    else $error("input ready right after a transfer");

  // A stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("stalled result changed or dropped");

  // No result without an item in flight
  a_no_extra_result: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> cnt_r != 2'd0)
    else $error("result shown with no item in flight");

  // At most one waiting result and one item in work
  a_bounded_flight: assert property (@(posedge clk) disable iff (!rst_n)
    in_xfer |-> cnt_r < 2'd2)
    else $error("input accepted with two items in flight");

endmodule

bind pendulum_runge_kutta_step prk_checker u_prk_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_ch.valid),
  .in_ready  (in_ch.ready),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .out_data  (out_ch.payload)
);
